/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent assertion on the usual clock and reset names.
`define ASSERT_CLK(label, prop) \
   `ASSERT_AT(label, clock, reset, prop)

`endif

/* hdl/i2a_pkg.sv */
// Types, codes and helper functions of the integer to ASCII converter.
package i2a_pkg;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] ascii_char;
      logic [4:0] char_count;
      logic       last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_PREFIX,
      ST_DIGITS
   } state_type;

   localparam logic [2:0] MODE_SDEC = 3'd0;
   localparam logic [2:0] MODE_UDEC = 3'd1;
   localparam logic [2:0] MODE_HEXL = 3'd2;
   localparam logic [2:0] MODE_HEXU = 3'd3;
   localparam logic [2:0] MODE_PTR  = 3'd4;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   localparam int BCD_DIGITS = 10;
   localparam int HEX_DIGITS = 16;

   // One digit to its ASCII code, with letters in the chosen case.
   function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib, input logic upper);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = CHAR_ZERO + {4'd0, nib};
      end else if (upper) begin
         r = CHAR_UPPER_A + {4'd0, nib} - 8'd10;
      end else begin
         r = CHAR_LOWER_A + {4'd0, nib} - 8'd10;
      end
      return r;
   endfunction

   // One shift-and-add-3 step: correct each BCD digit, then shift in one bit.
   function automatic logic [4*BCD_DIGITS-1:0] dabble(
      input logic [4*BCD_DIGITS-1:0] bcd,
      input logic                    bit_in
   );
      logic [4*BCD_DIGITS-1:0] adj;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd[4*i +: 4];
         end
      end
      return {adj[4*BCD_DIGITS-2:0], bit_in};
   endfunction

endpackage

/* hdl/integer_to_ascii_converter_top.sv */
// Top level of the integer to ASCII converter.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    i2a_pkg::req_payload_type (mode, value)
//   rsp      out        rsp_valid/stall    i2a_pkg::rsp_payload_type (char, count, last)
//
// A hex transaction is accepted in idle and then walks the 16 digits; pointer form
// first emits the "0x" prefix. A decimal transaction is accepted, converts the
// 32-bit value bit-serially from binary to BCD, emits a minus sign if the value
// is negative, and then walks the 10 digits.
// Reset is synchronous and clears the sequencer and the output valid flag.
// A stalled result only pauses the character that waits for the output slot.
module integer_to_ascii_converter_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  i2a_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output i2a_pkg::rsp_payload_type rsp_data
);

   localparam int BCD_W = 4 * i2a_pkg::BCD_DIGITS;

   i2a_pkg::state_type       state_ff, state_in;
   logic                     upper_ff, upper_in;
   logic                     neg_ff, neg_in;
   logic [31:0]              bin_ff, bin_in;
   logic [63:0]              dig_ff, dig_in;
   logic [4:0]               bit_cnt_ff, bit_cnt_in;
   logic [4:0]               nib_left_ff, nib_left_in;
   logic                     pre_sel_ff, pre_sel_in;
   logic                     started_ff, started_in;
   logic [4:0]               pos_ff, pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   i2a_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic             req_accept;
   logic             slot_free;
   logic             is_dec;
   logic             conv_done;
   logic             pre_last;
   logic [3:0]       nib;
   logic             nib_show;
   logic [BCD_W-1:0] bcd_next;

   // The block takes one transaction at a time; the output register decouples
   // the final character from the next request.
   assign req_stall  = (state_ff != i2a_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   assign is_dec    = (req_data.mode == i2a_pkg::MODE_SDEC) ||
                      (req_data.mode == i2a_pkg::MODE_UDEC);
   assign conv_done = (bit_cnt_ff == 5'd31);
   assign pre_last  = neg_ff || pre_sel_ff;
   assign nib       = dig_ff[63:60];
   // Leading zeros are skipped, but the final digit always prints.
   assign nib_show  = started_ff || (nib != 4'd0) || (nib_left_ff == 5'd1);
   assign bcd_next  = i2a_pkg::dabble(dig_ff[BCD_W-1:0], bin_ff[31]);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         i2a_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (is_dec) begin
                  state_in = i2a_pkg::ST_CONV;
               end else if (req_data.mode == i2a_pkg::MODE_PTR) begin
                  state_in = i2a_pkg::ST_PREFIX;
               end else begin
                  state_in = i2a_pkg::ST_DIGITS;
               end
            end
         end
         i2a_pkg::ST_CONV: begin
            if (conv_done) begin
               state_in = neg_ff ? i2a_pkg::ST_PREFIX : i2a_pkg::ST_DIGITS;
            end
         end
         i2a_pkg::ST_PREFIX: begin
            if (slot_free && pre_last) begin
               state_in = i2a_pkg::ST_DIGITS;
            end
         end
         i2a_pkg::ST_DIGITS: begin
            if (slot_free && (nib_left_ff == 5'd1)) begin
               state_in = i2a_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = i2a_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and output register updates.
   always_comb begin
      upper_in     = upper_ff;
      neg_in       = neg_ff;
      bin_in       = bin_ff;
      dig_in       = dig_ff;
      bit_cnt_in   = bit_cnt_ff;
      nib_left_in  = nib_left_ff;
      pre_sel_in   = pre_sel_ff;
      started_in   = started_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         i2a_pkg::ST_IDLE: begin
            if (req_accept) begin
               upper_in    = (req_data.mode == i2a_pkg::MODE_HEXU);
               neg_in      = (req_data.mode == i2a_pkg::MODE_SDEC) && req_data.value[31];
               pos_in      = 5'd0;
               started_in  = 1'b0;
               pre_sel_in  = 1'b0;
               bit_cnt_in  = 5'd0;
               nib_left_in = 5'(i2a_pkg::HEX_DIGITS);
               // The magnitude of the most negative value wraps to itself,
               // which reads correctly as an unsigned number.
               if ((req_data.mode == i2a_pkg::MODE_SDEC) && req_data.value[31]) begin
                  bin_in = 32'd0 - req_data.value[31:0];
               end else begin
                  bin_in = req_data.value[31:0];
               end
               dig_in = is_dec ? 64'd0 : req_data.value;
            end
         end
         i2a_pkg::ST_CONV: begin
            bin_in     = {bin_ff[30:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 5'd1;
            if (conv_done) begin
               // Move the BCD digits to the top so the digit walk starts there.
               dig_in      = {bcd_next, {(64 - BCD_W){1'b0}}};
               nib_left_in = 5'(i2a_pkg::BCD_DIGITS);
            end else begin
               dig_in = {{(64 - BCD_W){1'b0}}, bcd_next};
            end
         end
         i2a_pkg::ST_PREFIX: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.char_count = pos_ff + 5'd1;
               rsp_data_in.last       = 1'b0;
               if (neg_ff) begin
                  rsp_data_in.ascii_char = i2a_pkg::CHAR_MINUS;
               end else if (pre_sel_ff) begin
                  rsp_data_in.ascii_char = i2a_pkg::CHAR_X;
               end else begin
                  rsp_data_in.ascii_char = i2a_pkg::CHAR_ZERO;
               end
               pos_in     = pos_ff + 5'd1;
               pre_sel_in = 1'b1;
            end
         end
         i2a_pkg::ST_DIGITS: begin
            if (!nib_show) begin
               dig_in      = {dig_ff[59:0], 4'd0};
               nib_left_in = nib_left_ff - 5'd1;
            end else if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.ascii_char = i2a_pkg::nib_to_ascii(nib, upper_ff);
               rsp_data_in.char_count = pos_ff + 5'd1;
               rsp_data_in.last       = (nib_left_ff == 5'd1);
               dig_in                 = {dig_ff[59:0], 4'd0};
               nib_left_in            = nib_left_ff - 5'd1;
               started_in             = 1'b1;
               pos_in                 = pos_ff + 5'd1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2a_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      upper_ff    <= upper_in;
      neg_ff      <= neg_in;
      bin_ff      <= bin_in;
      dig_ff      <= dig_in;
      bit_cnt_ff  <= bit_cnt_in;
      nib_left_ff <= nib_left_in;
      pre_sel_ff  <= pre_sel_in;
      started_ff  <= started_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/i2a_checker.sv */
// Port-level checker of the integer to ASCII converter and its bind.
`include "assert_macros.svh"

module i2a_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input i2a_pkg::req_payload_type req_data,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input i2a_pkg::rsp_payload_type rsp_data
);

   logic count_ok;

   assign count_ok = (rsp_data.char_count != 5'd0) && (rsp_data.char_count <= 5'd18);

   `ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   `ASSERT_CLK(a_req_hold, req_valid && req_stall |=> req_valid && $stable(req_data))
   `ASSERT_CLK(a_count_range, rsp_valid |-> count_ok)
   `ASSERT_CLK(a_busy_after_req, req_valid && !req_stall |=> req_stall)
   `ASSERT_CLK(a_busy_mid_text, rsp_valid && !rsp_data.last |-> req_stall)

endmodule

bind integer_to_ascii_converter_top i2a_checker u_i2a_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
